// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the button press classifier
// Item layouts, configuration register set and register indexes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

   localparam int MASK_W     = 3;
   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0] SHORT_TICKS_RST  = CNT_W'(4);
   localparam logic [CNT_W-1:0] LONG_TICKS_RST   = CNT_W'(125);
   localparam logic [CNT_W-1:0] REPEAT_LIMIT_RST = CNT_W'(200);
   localparam logic [CNT_W-1:0] CNT_MAX          = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_TICKS  = 2'd0,
      CSR_LONG_TICKS   = 2'd1,
      CSR_REPEAT_LIMIT = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [CNT_W-1:0] short_press_ticks;
      logic [CNT_W-1:0] long_press_ticks;
      logic [CNT_W-1:0] repeat_limit_ticks;
   } cfg_type;

   typedef struct packed {
      logic              clear_short;
      logic [MASK_W-1:0] keys_down;
   } req_item_type;

   typedef struct packed {
      logic              flag_long;
      logic              flag_short;
      logic              flag_released;
      logic              flag_pressed;
      logic [MASK_W-1:0] key_qualified;
      logic [MASK_W-1:0] key_now;
   } rsp_item_type;

   typedef struct packed {
      logic long_held;
      logic short_done;
      logic released;
      logic pressed;
   } flags_type;

endpackage

`default_nettype wire

// ===== rtl/bpc_if.sv =====
// ----------------------------------------------------------------------------
// bpc_if: valid/ready channels of the button press classifier
// Request channel carries one scan tick, response channel one classification.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_req_if;
   logic                       valid;
   logic                       ready;
   logic [bpc_pkg::MASK_W-1:0] keys_down;
   logic                       clear_short;

   modport source (output valid, output keys_down, output clear_short, input ready);
   modport sink   (input valid, input keys_down, input clear_short, output ready);
endinterface

interface bpc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bpc_pkg::MASK_W-1:0] key_now;
   logic [bpc_pkg::MASK_W-1:0] key_qualified;
   logic                       flag_pressed;
   logic                       flag_released;
   logic                       flag_short;
   logic                       flag_long;

   modport source (output valid, output key_now, output key_qualified, output flag_pressed,
                   output flag_released, output flag_short, output flag_long,
                   input ready);
   modport sink   (input valid, input key_now, input key_qualified, input flag_pressed,
                   input flag_released, input flag_short, input flag_long,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/bpc_csr.sv =====
// ----------------------------------------------------------------------------
// bpc_csr: threshold registers
// Write-only register file holding the short, long and repeat thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output bpc_pkg::cfg_type                    cfg
);

   bpc_pkg::cfg_type cfg_ff;
   bpc_pkg::cfg_type cfg_in;

   // decode the write; unused indexes drop the data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (bpc_pkg::csr_idx_type'(csr_index))
            bpc_pkg::CSR_SHORT_TICKS:  cfg_in.short_press_ticks  = csr_wdata;
            bpc_pkg::CSR_LONG_TICKS:   cfg_in.long_press_ticks   = csr_wdata;
            bpc_pkg::CSR_REPEAT_LIMIT: cfg_in.repeat_limit_ticks = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_press_ticks  <= bpc_pkg::SHORT_TICKS_RST;
         cfg_ff.long_press_ticks   <= bpc_pkg::LONG_TICKS_RST;
         cfg_ff.repeat_limit_ticks <= bpc_pkg::REPEAT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/bpc_core.sv =====
// ----------------------------------------------------------------------------
// bpc_core: press classification state and next-state logic
// Holds the mask, hold counter and flags; classifies one scan tick per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  bpc_pkg::req_item_type  item,
   input  bpc_pkg::cfg_type       cfg,
   output bpc_pkg::rsp_item_type  result
);

   logic [bpc_pkg::MASK_W-1:0] held_mask_ff;
   logic [bpc_pkg::MASK_W-1:0] held_mask_in;
   logic [bpc_pkg::CNT_W-1:0]  hold_counter_ff;
   logic [bpc_pkg::CNT_W-1:0]  hold_counter_in;
   bpc_pkg::flags_type         flags_ff;
   bpc_pkg::flags_type         flags_in;
   logic [bpc_pkg::MASK_W-1:0] key_qualified;
   logic                       mask_changed;
   logic                       cnt_can_inc;

   assign mask_changed = (item.keys_down != held_mask_ff);
   assign cnt_can_inc  = (hold_counter_ff <= cfg.repeat_limit_ticks) &&
                         (hold_counter_ff != bpc_pkg::CNT_MAX);

   // classify the tick: acknowledge first, then change or hold handling
   always_comb begin
      flags_in        = flags_ff;
      held_mask_in    = held_mask_ff;
      hold_counter_in = hold_counter_ff;
      key_qualified   = '0;
      if (item.clear_short) begin
         flags_in.short_done = 1'b0;
      end
      if (mask_changed) begin
         flags_in.released = 1'b1;
         if ((held_mask_ff != '0) && (hold_counter_ff >= cfg.short_press_ticks)) begin
            flags_in.pressed    = 1'b0;
            flags_in.long_held  = 1'b0;
            flags_in.short_done = 1'b1;
            key_qualified       = held_mask_ff;
         end
         hold_counter_in = '0;
         held_mask_in    = item.keys_down;
      end else if (item.keys_down != '0) begin
         if (cnt_can_inc) begin
            hold_counter_in = hold_counter_ff + bpc_pkg::CNT_W'(1);
         end
         if (hold_counter_in >= cfg.long_press_ticks) begin
            flags_in.long_held = 1'b1;
            key_qualified      = held_mask_ff;
         end
         if (hold_counter_in == cfg.short_press_ticks) begin
            flags_in.pressed  = 1'b1;
            flags_in.released = 1'b0;
            key_qualified     = held_mask_ff;
         end
      end
   end

   // commit state only when the tick moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         held_mask_ff    <= '0;
         hold_counter_ff <= '0;
         flags_ff        <= '0;
      end else if (advance) begin
         held_mask_ff    <= held_mask_in;
         hold_counter_ff <= hold_counter_in;
         flags_ff        <= flags_in;
      end
   end

   always_comb begin
      result.key_now       = item.keys_down;
      result.key_qualified = key_qualified;
      result.flag_pressed  = flags_in.pressed;
      result.flag_released = flags_in.released;
      result.flag_short    = flags_in.short_done;
      result.flag_long     = flags_in.long_held;
   end

   // a changed mask restarts the hold count
   a_change_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && mask_changed) |=> (hold_counter_ff == '0))
      else $error("hold counter not restarted after mask change");

   // state holds while no tick advances
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(held_mask_ff) && $stable(hold_counter_ff) && $stable(flags_ff)))
      else $error("classifier state moved without a tick");

   // a qualified release is a short press that ends pressed and long
   a_release_short: assert property (@(posedge clock) disable iff (reset)
      (advance && mask_changed && (result.key_qualified != '0)) |->
      (result.flag_short && !result.flag_pressed && !result.flag_long))
      else $error("qualified release without short press");

   // a reported mask is always the held mask
   a_valid_is_held: assert property (@(posedge clock) disable iff (reset)
      (advance && (result.key_qualified != '0)) |-> (result.key_qualified == held_mask_ff))
      else $error("reported mask differs from held mask");

endmodule

`default_nettype wire

// ===== rtl/button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_classifier: debounce and short/long press classification
// Three-button scan ticks in, one classification per tick out.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one scan tick per item: the pressed mask keys_down and
//   clear_short, which acknowledges a pending short press before the tick.
//   rsp_chan returns exactly one item per tick: the sampled mask, the mask
//   qualified this tick (0 if none) and the four press flags after the tick.
//   Thresholds are written through csr_write_en/csr_index/csr_wdata while
//   no tick is in flight; index 0 short, 1 long, 2 repeat limit, others
//   are ignored.
//   After acceptance the tick waits in the input register and is then
//   classified into the result register, from which rsp_chan takes it.
//   Throughput is one item per cycle while rsp_chan.ready stays high,
//   with the compare/increment path lying between those two registers.
//   Reset clears the held mask, hold counter and flags, loads the default
//   thresholds (4, 125, 200) and empties both registers.
//   When the receiver stalls the result register holds, the input register
//   takes one more item, and then req_chan.ready drops until rsp_chan moves.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier (
   input  logic                            clock,
   input  logic                            reset,
   bpc_req_if.sink                         req_chan,
   bpc_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bpc_pkg::cfg_type       cfg;
   bpc_pkg::req_item_type  in_item_ff;
   bpc_pkg::req_item_type  in_item_in;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   bpc_pkg::rsp_item_type  out_item_ff;
   bpc_pkg::rsp_item_type  core_result;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic                   out_free;
   logic                   advance;
   logic                   req_take;

   bpc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // handshake: result register frees when empty or taken
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // input register: load on accept, drain on advance
   always_comb begin
      in_item_in  = in_item_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_item_in.keys_down   = req_chan.keys_down;
         in_item_in.clear_short = req_chan.clear_short;
         in_valid_in            = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   bpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   // result register: load on advance, hold while stalled
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.key_now       = out_item_ff.key_now;
   assign rsp_chan.key_qualified = out_item_ff.key_qualified;
   assign rsp_chan.flag_pressed  = out_item_ff.flag_pressed;
   assign rsp_chan.flag_released = out_item_ff.flag_released;
   assign rsp_chan.flag_short    = out_item_ff.flag_short;
   assign rsp_chan.flag_long     = out_item_ff.flag_long;

endmodule

`default_nettype wire

// ===== dv/press_classifier_checker.sv =====
// ----------------------------------------------------------------------------
// press_classifier_checker: result checker for the button press classifier
// Watches the scan tick, result and register write ports, classifies every
// accepted tick with its own copy of the thresholds, held mask, hold counter
// and press flags, and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module press_classifier_checker (
   input  logic                           clock,
   input  logic                           reset,
   bpc_req_if                             req_mon,
   bpc_rsp_if                             rsp_mon,
   input  logic                           csr_write_en,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             failures,
   output int                             outstanding,
   output int                             ticks_checked,
   output int                             presses_reported
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 40;
   localparam int FIELD_W     = bpc_pkg::CNT_W;

   bpc_pkg::cfg_type                thresholds;
   logic [bpc_pkg::MASK_W-1:0]      held_keys;
   logic [bpc_pkg::CNT_W-1:0]       hold_count;
   bpc_pkg::flags_type              press_state;
   bpc_pkg::rsp_item_type           predicted_ticks[$];

   // Print one line per mismatch (up to a cap) and count it
   task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                  input logic [FIELD_W-1:0] want);
      if (failures < MAX_REPORTS)
         $display("%0t: result %0d %s: got %0h, want %0h",
                  $time, ticks_checked, what, got, want);
      failures++;
   endtask

   // Classify one scan tick and advance the held mask, counter and flags
   function automatic bpc_pkg::rsp_item_type classify_tick(input bpc_pkg::req_item_type tick);
      bpc_pkg::rsp_item_type      result;
      logic [bpc_pkg::MASK_W-1:0] qualified;
      qualified = '0;
      // the acknowledge lands before anything else this tick
      if (tick.clear_short)
         press_state.short_done = 1'b0;
      if (tick.keys_down != held_keys) begin
         // mask changed: end the hold, report it if it lasted long enough
         press_state.released = 1'b1;
         if (held_keys != '0 && hold_count >= thresholds.short_press_ticks) begin
            press_state.pressed    = 1'b0;
            press_state.long_held  = 1'b0;
            press_state.short_done = 1'b1;
            qualified              = held_keys;
         end
         hold_count = '0;
         held_keys  = tick.keys_down;
      end else if (tick.keys_down != '0) begin
         // same nonzero mask: count up, stop one past the repeat limit
         if (hold_count <= thresholds.repeat_limit_ticks && hold_count != bpc_pkg::CNT_MAX)
            hold_count = hold_count + FIELD_W'(1);
         if (hold_count >= thresholds.long_press_ticks) begin
            press_state.long_held = 1'b1;
            qualified             = held_keys;
         end
         if (hold_count == thresholds.short_press_ticks) begin
            press_state.pressed  = 1'b1;
            press_state.released = 1'b0;
            qualified            = held_keys;
         end
      end
      result.key_now       = tick.keys_down;
      result.key_qualified = qualified;
      result.flag_pressed  = press_state.pressed;
      result.flag_released = press_state.released;
      result.flag_short    = press_state.short_done;
      result.flag_long     = press_state.long_held;
      return result;
   endfunction

   always @(posedge clock) begin : monitor
      bpc_pkg::req_item_type tick;
      bpc_pkg::rsp_item_type seen;
      bpc_pkg::rsp_item_type want;
      if (reset) begin
         thresholds.short_press_ticks  = bpc_pkg::SHORT_TICKS_RST;
         thresholds.long_press_ticks   = bpc_pkg::LONG_TICKS_RST;
         thresholds.repeat_limit_ticks = bpc_pkg::REPEAT_LIMIT_RST;
         held_keys   = '0;
         hold_count  = '0;
         press_state = '0;
         predicted_ticks.delete();
         failures         = 0;
         ticks_checked    = 0;
         presses_reported = 0;
         outstanding <= 0;
      end else begin
         // register writes; unused indexes fall through
         if (csr_write_en) begin
            case (csr_index)
               bpc_pkg::CSR_SHORT_TICKS:  thresholds.short_press_ticks  = csr_wdata;
               bpc_pkg::CSR_LONG_TICKS:   thresholds.long_press_ticks   = csr_wdata;
               bpc_pkg::CSR_REPEAT_LIMIT: thresholds.repeat_limit_ticks = csr_wdata;
               default: ;
            endcase
         end
         // compare an accepted result with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.key_now       = rsp_mon.key_now;
            seen.key_qualified = rsp_mon.key_qualified;
            seen.flag_pressed  = rsp_mon.flag_pressed;
            seen.flag_released = rsp_mon.flag_released;
            seen.flag_short    = rsp_mon.flag_short;
            seen.flag_long     = rsp_mon.flag_long;
            if (predicted_ticks.size() == 0) begin
               report_mismatch("result with no tick pending", FIELD_W'(seen), '0);
            end else begin
               want = predicted_ticks.pop_front();
               if (seen.key_now !== want.key_now)
                  report_mismatch("key_now", FIELD_W'(seen.key_now),
                                  FIELD_W'(want.key_now));
               if (seen.key_qualified !== want.key_qualified)
                  report_mismatch("key_qualified", FIELD_W'(seen.key_qualified),
                                  FIELD_W'(want.key_qualified));
               if (seen.flag_pressed !== want.flag_pressed)
                  report_mismatch("flag_pressed", FIELD_W'(seen.flag_pressed),
                                  FIELD_W'(want.flag_pressed));
               if (seen.flag_released !== want.flag_released)
                  report_mismatch("flag_released", FIELD_W'(seen.flag_released),
                                  FIELD_W'(want.flag_released));
               if (seen.flag_short !== want.flag_short)
                  report_mismatch("flag_short", FIELD_W'(seen.flag_short),
                                  FIELD_W'(want.flag_short));
               if (seen.flag_long !== want.flag_long)
                  report_mismatch("flag_long", FIELD_W'(seen.flag_long),
                                  FIELD_W'(want.flag_long));
            end
            if (seen.key_qualified != '0)
               presses_reported++;
            ticks_checked++;
         end
         // predict the result of an accepted tick
         if (req_mon.valid && req_mon.ready) begin
            tick.keys_down   = req_mon.keys_down;
            tick.clear_short = req_mon.clear_short;
            predicted_ticks.push_back(classify_tick(tick));
         end
         outstanding <= predicted_ticks.size();
      end
   end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench top of the button press classifier
// Drives scan ticks and threshold writes, stalls the result side at random,
// and gives the verdict from the checker's failure and outstanding counts.
// A short directed run comes first, then random press/hold/release runs under
// several settings, including zero thresholds and a full-scale repeat limit.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT        = 6;
   localparam int HOLD_OFF_CYCLES = 40;
   localparam int DRAIN_CYCLES    = 6;
   localparam int MAX_HOLD        = 260;
   localparam int QUIET_FIRST     = 600;
   localparam int QUIET_LAST      = 800;
   localparam int SETTINGS_RUN    = 7;
   localparam logic [bpc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_en;
   logic [bpc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bpc_pkg::CSR_DATA_W-1:0] csr_wdata;

   int failures;
   int outstanding;
   int ticks_checked;
   int presses_reported;
   int items_sent       = 0;
   int hold_offs_asked  = 0;
   int hold_offs_served = 0;

   // thresholds in force, used only to shape hold lengths
   int short_ticks;
   int long_ticks;
   int repeat_ticks;

   bpc_req_if req_chan ();
   bpc_rsp_if rsp_chan ();

   button_press_classifier uut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   press_classifier_checker press_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .outstanding      (outstanding),
      .ticks_checked    (ticks_checked),
      .presses_reported (presses_reported)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // a stretch of ticks during which neither side idles
   function automatic bit quiet_window();
      return items_sent >= QUIET_FIRST && items_sent < QUIET_LAST;
   endfunction

   // Offer one scan tick, idling now and then, and hold until accepted
   task automatic send_tick(input logic [bpc_pkg::MASK_W-1:0] keys, input logic ack);
      while (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.keys_down   <= keys;
      req_chan.clear_short <= ack;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic hold_keys(input logic [bpc_pkg::MASK_W-1:0] keys, input int ticks);
      repeat (ticks) send_tick(keys, $urandom_range(3) == 0);
   endtask

   // Wait until every result is back, then let the pipeline settle
   task automatic wait_drained();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bpc_pkg::CSR_IDX_W-1:0] idx, input int data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= bpc_pkg::CSR_DATA_W'(data);
      @(posedge clock);
   endtask

   // Drain the block, optionally poke the unused index, then load all three thresholds back to back
   task automatic set_thresholds(input int s, input int l, input int r,
                                 input bit poke_unused);
      req_chan.valid <= 1'b0;
      wait_drained();
      if (poke_unused)
         write_csr(CSR_UNUSED, 'hbeef);
      write_csr(bpc_pkg::CSR_SHORT_TICKS, s);
      write_csr(bpc_pkg::CSR_LONG_TICKS, l);
      write_csr(bpc_pkg::CSR_REPEAT_LIMIT, r);
      csr_write_en <= 1'b0;
      short_ticks  = s;
      long_ticks   = l;
      repeat_ticks = r;
   endtask

   // Directed opening under the reset thresholds
   task automatic directed_ticks();
      send_tick(3'b000, 1'b0);              // nothing held
      send_tick(3'b000, 1'b1);              // acknowledge with nothing pending
      repeat (5) send_tick(3'b001, 1'b0);   // reach the short count
      send_tick(3'b111, 1'b0);              // change after short count: report
      repeat (2) send_tick(3'b111, 1'b1);   // acknowledge the short press
      send_tick(3'b000, 1'b0);              // release before short count
      repeat (5) send_tick(3'b010, 1'b0);
      send_tick(3'b100, 1'b1);              // acknowledge and new short together
      send_tick(3'b000, 1'b0);
   endtask

   // Random press/hold/release sequences with holds aimed at the thresholds
   task automatic random_presses(input int n_items);
      int                         budget;
      int                         ticks;
      int                         lo;
      int                         hi;
      logic [bpc_pkg::MASK_W-1:0] keys;
      budget = n_items;
      while (budget > 0) begin
         keys = ($urandom_range(99) < 30) ? '0 : bpc_pkg::MASK_W'($urandom_range(7));
         case ($urandom_range(4))
            0: begin lo = short_ticks;      hi = short_ticks + 2;  end
            1: begin lo = long_ticks;       hi = long_ticks + 3;   end
            2: begin lo = repeat_ticks + 1; hi = repeat_ticks + 4; end
            3: begin lo = 1;                hi = 3;                end  // bounce
            default: begin lo = 1;          hi = 12;               end
         endcase
         if (hi > MAX_HOLD) hi = MAX_HOLD;
         if (lo > hi) lo = hi - 8;
         if (lo < 1) lo = 1;
         ticks = $urandom_range(hi, lo);
         if (ticks > budget) ticks = budget;
         hold_keys(keys, ticks);
         budget -= ticks;
      end
   endtask

   // Result side: random stalls, plus a long hold-off when asked
   initial begin
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_offs_served < hold_offs_asked) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_offs_served++;
         end else begin
            rsp_chan.ready <= quiet_window() || $urandom_range(99) >= IDLE_PCT;
            @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.keys_down   <= '0;
      req_chan.clear_short <= 1'b0;
      csr_write_en         <= 1'b0;
      csr_index            <= bpc_pkg::CSR_SHORT_TICKS;
      csr_wdata            <= '0;
      short_ticks  = bpc_pkg::SHORT_TICKS_RST;
      long_ticks   = bpc_pkg::LONG_TICKS_RST;
      repeat_ticks = bpc_pkg::REPEAT_LIMIT_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_ticks();
      random_presses(300);

      set_thresholds(1, 3, 5, 1'b1);
      random_presses(150);

      // repeat limit below the long count: long is never reached
      set_thresholds(2, 6, 4, 1'b0);
      hold_offs_asked++;
      random_presses(150);

      set_thresholds(3, 3, 3, 1'b0);
      random_presses(100);

      set_thresholds(5, 2, 65534, 1'b1);
      random_presses(150);

      set_thresholds(0, 0, 0, 1'b0);
      random_presses(150);

      set_thresholds(20, 60, 65535, 1'b0);
      hold_offs_asked++;
      random_presses(150);

      req_chan.valid <= 1'b0;
      wait_drained();

      $display("covered %0d scan ticks under %0d threshold settings",
               items_sent, SETTINGS_RUN);
      $display("checked %0d results, %0d of them carrying a qualified key mask",
               ticks_checked, presses_reported);
      if (failures == 0 && outstanding == 0) begin
         $display("button_press_classifier: match");
      end else begin
         $display("button_press_classifier: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #6ms;
      $display("button_press_classifier: mismatch");
      $finish;
   end

endmodule

// ===== button_press_classifier.f =====
rtl/bpc_pkg.sv
rtl/bpc_if.sv
rtl/bpc_csr.sv
rtl/bpc_core.sv
rtl/button_press_classifier.sv
dv/press_classifier_checker.sv
dv/tb_top.sv
